@@ rtl/core/pbcn_pkg.sv @@
// Shared types, constants and state codes of the point bounding-box normalizer.
package pbcn_pkg;

	// Coordinate format: signed Q16.16.
	localparam int COORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int COL_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// A coordinate difference needs one more bit than a coordinate.
	localparam int DIFF_W = COORD_W + 1;
	// Products and squared distances are kept in 64 bits; none of them overflows.
	localparam int PROD_W = 2 * COORD_W;
	localparam int FULL_W = DIFF_W + COORD_W;
	// Rounded product magnitude after the fraction bits are dropped.
	localparam int MAG_W = PROD_W - FRAC_W;
	// Dividend of the scale division: target_extent with two fractions appended.
	localparam int NUM_W = CFG_W + 2 * FRAC_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
	localparam logic [COORD_W-1:0] SCALE_ONE = COORD_W'(1) << FRAC_W;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_RADIUS_SQ = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_EXTENT = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] RESET_REJECT_RADIUS_SQ = CFG_W'(100);
	localparam logic [CFG_W-1:0] RESET_TARGET_EXTENT = CFG_W'(128);

	// Axis selects of the shared multiplier.
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef enum logic {
		MODE_SQUARE,
		MODE_SCALE
	} mul_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SQ_WAIT,
		ST_CHECK,
		ST_SC_MAX,
		ST_DIV,
		ST_DIV_FIN,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_MUL_WAIT,
		ST_OUT
	} pbcn_state_t;

	typedef struct packed {
		logic calibrating;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic point_invalid;
		logic [COL_W-1:0] col_r;
		logic [COL_W-1:0] col_g;
		logic [COL_W-1:0] col_b;
		logic frame_end;
	} pbcn_in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] norm_x;
		logic signed [COORD_W-1:0] norm_y;
		logic signed [COORD_W-1:0] norm_z;
		logic [COL_W-1:0] out_r;
		logic [COL_W-1:0] out_g;
		logic [COL_W-1:0] out_b;
		logic last_of_frame;
	} pbcn_out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic in_ready;
		logic load;
		logic mul_en;
		mul_mode_t mul_mode;
		axis_t mul_axis;
		logic check;
		logic scale_start;
		logic div_step;
		logic div_finish;
		logic out_load;
	} pbcn_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scale_ok;
		logic side_pos;
		logic div_last;
		logic out_free;
	} pbcn_status_t;

endpackage

@@ rtl/core/pbcn_if.sv @@
// Handshake channel interfaces for points, results and configuration writes.
interface pbcn_in_if;
	logic valid;
	logic ready;
	pbcn_pkg::pbcn_in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pbcn_out_if;
	logic valid;
	logic ready;
	pbcn_pkg::pbcn_out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pbcn_cfg_if;
	logic valid;
	logic ready;
	logic [pbcn_pkg::CFG_IDX_W-1:0] index;
	logic [pbcn_pkg::CFG_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/pbcn_ctrl.sv @@
// Sequencing state machine of the point bounding-box normalizer.
module pbcn_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_cal,
	input  pbcn_pkg::pbcn_status_t status,
	output pbcn_pkg::pbcn_cmd_t    cmd
);

	pbcn_pkg::pbcn_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbcn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pbcn_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_cal) begin
						state_d = pbcn_pkg::ST_SQ_X;
					end else if (status.scale_ok) begin
						state_d = pbcn_pkg::ST_MUL_X;
					end else begin
						state_d = pbcn_pkg::ST_SC_MAX;
					end
				end
			end
			pbcn_pkg::ST_SQ_X:     state_d = pbcn_pkg::ST_SQ_Y;
			pbcn_pkg::ST_SQ_Y:     state_d = pbcn_pkg::ST_SQ_Z;
			pbcn_pkg::ST_SQ_Z:     state_d = pbcn_pkg::ST_SQ_WAIT;
			pbcn_pkg::ST_SQ_WAIT:  state_d = pbcn_pkg::ST_CHECK;
			pbcn_pkg::ST_CHECK:    state_d = pbcn_pkg::ST_IDLE;
			pbcn_pkg::ST_SC_MAX: begin
				state_d = status.side_pos ? pbcn_pkg::ST_DIV : pbcn_pkg::ST_MUL_X;
			end
			pbcn_pkg::ST_DIV: begin
				if (status.div_last) begin
					state_d = pbcn_pkg::ST_DIV_FIN;
				end
			end
			pbcn_pkg::ST_DIV_FIN:  state_d = pbcn_pkg::ST_MUL_X;
			pbcn_pkg::ST_MUL_X:    state_d = pbcn_pkg::ST_MUL_Y;
			pbcn_pkg::ST_MUL_Y:    state_d = pbcn_pkg::ST_MUL_Z;
			pbcn_pkg::ST_MUL_Z:    state_d = pbcn_pkg::ST_MUL_WAIT;
			pbcn_pkg::ST_MUL_WAIT: state_d = pbcn_pkg::ST_OUT;
			pbcn_pkg::ST_OUT: begin
				if (status.out_free) begin
					state_d = pbcn_pkg::ST_IDLE;
				end
			end
			default:               state_d = pbcn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_mode = pbcn_pkg::MODE_SQUARE;
		cmd.mul_axis = pbcn_pkg::AXIS_X;
		case (state_q)
			pbcn_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pbcn_pkg::ST_SQ_X: begin
				cmd.mul_en = 1'b1;
			end
			pbcn_pkg::ST_SQ_Y: begin
				cmd.mul_en = 1'b1;
				cmd.mul_axis = pbcn_pkg::AXIS_Y;
			end
			pbcn_pkg::ST_SQ_Z: begin
				cmd.mul_en = 1'b1;
				cmd.mul_axis = pbcn_pkg::AXIS_Z;
			end
			pbcn_pkg::ST_CHECK:   cmd.check = 1'b1;
			pbcn_pkg::ST_SC_MAX:  cmd.scale_start = 1'b1;
			pbcn_pkg::ST_DIV:     cmd.div_step = 1'b1;
			pbcn_pkg::ST_DIV_FIN: cmd.div_finish = 1'b1;
			pbcn_pkg::ST_MUL_X: begin
				cmd.mul_en = 1'b1;
				cmd.mul_mode = pbcn_pkg::MODE_SCALE;
			end
			pbcn_pkg::ST_MUL_Y: begin
				cmd.mul_en = 1'b1;
				cmd.mul_mode = pbcn_pkg::MODE_SCALE;
				cmd.mul_axis = pbcn_pkg::AXIS_Y;
			end
			pbcn_pkg::ST_MUL_Z: begin
				cmd.mul_en = 1'b1;
				cmd.mul_mode = pbcn_pkg::MODE_SCALE;
				cmd.mul_axis = pbcn_pkg::AXIS_Z;
			end
			pbcn_pkg::ST_OUT:     cmd.out_load = status.out_free;
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/core/pbcn_datapath.sv @@
// Datapath: item and box registers, shared multiplier, scale divider, output register.
module pbcn_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbcn_pkg::pbcn_cmd_t           cmd,
	output pbcn_pkg::pbcn_status_t        status,
	input  pbcn_pkg::pbcn_in_item_t       in_item,
	input  logic                          cfg_we,
	input  logic [pbcn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbcn_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          out_ready,
	output logic                          out_valid,
	output pbcn_pkg::pbcn_out_item_t      out_item
);

	localparam int CW = pbcn_pkg::COORD_W;
	localparam int DW = pbcn_pkg::DIFF_W;
	localparam int PW = pbcn_pkg::PROD_W;
	localparam int NW = pbcn_pkg::NUM_W;
	localparam int MW = pbcn_pkg::MAG_W;

	// Item registers.
	logic signed [CW-1:0] pos_q [3];
	logic inv_q;
	logic [pbcn_pkg::COL_W-1:0] col_r_q, col_g_q, col_b_q;
	logic fe_q;

	// Box, scale and configuration state.
	logic signed [CW-1:0] box_min_q [3];
	logic signed [CW-1:0] box_max_q [3];
	logic [CW-1:0] scale_q;
	logic scale_ok_q;
	logic [pbcn_pkg::CFG_W-1:0] reject_q, extent_q;

	// Multiplier stage.
	logic [PW-1:0] prod_s1;
	logic vld_s1, neg_s1;
	pbcn_pkg::mul_mode_t mode_s1;
	pbcn_pkg::axis_t axis_s1;
	logic [PW-1:0] acc_q;
	logic signed [CW-1:0] res_q [3];

	// Divider.
	logic [DW-1:0] den_q, rem_q;
	logic [NW-1:0] dq_q;
	logic [pbcn_pkg::CNT_W-1:0] cnt_q;

	logic out_valid_q;
	pbcn_pkg::pbcn_out_item_t out_item_q;

	// Box sides and the largest of them.
	logic signed [DW-1:0] side [3];
	logic signed [DW-1:0] side_max;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side[i] = $signed({box_max_q[i][CW-1], box_max_q[i]})
				- $signed({box_min_q[i][CW-1], box_min_q[i]});
		end
		side_max = side[0];
		if (side[1] > side_max) begin
			side_max = side[1];
		end
		if (side[2] > side_max) begin
			side_max = side[2];
		end
	end

	// Multiplier operands.
	logic signed [CW-1:0] sel_pos, sel_min;
	logic signed [DW-1:0] diff;
	logic [DW-1:0] op_a, pos_mag;
	logic [CW-1:0] op_b;
	logic op_neg;
	logic [pbcn_pkg::FULL_W-1:0] full_prod;
	always_comb begin
		sel_pos = pos_q[cmd.mul_axis];
		sel_min = box_min_q[cmd.mul_axis];
		pos_mag = sel_pos[CW-1] ? DW'(-$signed({sel_pos[CW-1], sel_pos}))
			: DW'({1'b0, sel_pos});
		diff = $signed({sel_pos[CW-1], sel_pos}) - $signed({sel_min[CW-1], sel_min});
		if (cmd.mul_mode == pbcn_pkg::MODE_SCALE) begin
			op_neg = diff[DW-1];
			op_a = op_neg ? DW'(-diff) : DW'(diff);
			op_b = scale_q;
		end else begin
			op_neg = 1'b0;
			op_a = pos_mag;
			op_b = pos_mag[CW-1:0];
		end
		full_prod = op_a * op_b;
	end

	// Rounding and saturation of a scaled coordinate.
	logic [PW-1:0] rnd_sum;
	logic [MW-1:0] rnd_mag, rnd_lim, rnd_sat;
	logic [CW-1:0] rnd_res;
	always_comb begin
		rnd_sum = prod_s1 + pbcn_pkg::ROUND_HALF;
		rnd_mag = rnd_sum[PW-1:pbcn_pkg::FRAC_W];
		rnd_lim = MW'(pbcn_pkg::COORD_MAX) + MW'(neg_s1);
		rnd_sat = (rnd_mag > rnd_lim) ? rnd_lim : rnd_mag;
		rnd_res = neg_s1 ? -rnd_sat[CW-1:0] : rnd_sat[CW-1:0];
	end

	// One restoring division step and the final rounding.
	logic [DW:0] rem_sh;
	logic div_ge;
	logic [NW:0] q_rnd;
	logic far_point;
	always_comb begin
		rem_sh = {rem_q, dq_q[NW-1]};
		div_ge = rem_sh >= {1'b0, den_q};
		q_rnd = {1'b0, dq_q} + (NW + 1)'(rem_q >= (den_q - rem_q));
		far_point = acc_q > {{(PW - NW){1'b0}}, reject_q, {(2 * pbcn_pkg::FRAC_W){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q[0] <= in_item.pos_x;
			pos_q[1] <= in_item.pos_y;
			pos_q[2] <= in_item.pos_z;
			inv_q <= in_item.point_invalid;
			col_r_q <= in_item.col_r;
			col_g_q <= in_item.col_g;
			col_b_q <= in_item.col_b;
			fe_q <= in_item.frame_end;
		end
		if (cmd.mul_en) begin
			prod_s1 <= full_prod[PW-1:0];
			neg_s1 <= op_neg;
			mode_s1 <= cmd.mul_mode;
			axis_s1 <= cmd.mul_axis;
		end
		if (vld_s1) begin
			if (mode_s1 == pbcn_pkg::MODE_SQUARE) begin
				acc_q <= (axis_s1 == pbcn_pkg::AXIS_X) ? prod_s1 : acc_q + prod_s1;
			end else begin
				res_q[axis_s1] <= rnd_res;
			end
		end
		if (cmd.scale_start) begin
			den_q <= side_max;
			rem_q <= '0;
			dq_q <= {extent_q, {(2 * pbcn_pkg::FRAC_W){1'b0}}};
			if (!side_max[DW-1] && side_max != '0) begin
			end else begin
				scale_q <= pbcn_pkg::SCALE_ONE;
			end
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			dq_q <= {dq_q[NW-2:0], div_ge};
		end
		if (cmd.div_finish) begin
			scale_q <= (q_rnd > (NW + 1)'(pbcn_pkg::COORD_MAX)) ? pbcn_pkg::COORD_MAX
				: q_rnd[CW-1:0];
		end
		if (cmd.out_load) begin
			out_item_q.norm_x <= res_q[0];
			out_item_q.norm_y <= res_q[1];
			out_item_q.norm_z <= res_q[2];
			out_item_q.out_r <= col_r_q;
			out_item_q.out_g <= col_g_q;
			out_item_q.out_b <= col_b_q;
			out_item_q.last_of_frame <= fe_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= pbcn_pkg::COORD_MAX;
				box_max_q[i] <= pbcn_pkg::COORD_MIN;
			end
			scale_ok_q <= 1'b0;
			reject_q <= pbcn_pkg::RESET_REJECT_RADIUS_SQ;
			extent_q <= pbcn_pkg::RESET_TARGET_EXTENT;
			vld_s1 <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_en;
			if (cfg_we) begin
				case (cfg_index)
					pbcn_pkg::REG_REJECT_RADIUS_SQ: reject_q <= cfg_wdata;
					pbcn_pkg::REG_TARGET_EXTENT: begin
						extent_q <= cfg_wdata;
						scale_ok_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.check && !inv_q && !far_point) begin
				for (int i = 0; i < 3; i++) begin
					if (pos_q[i] < box_min_q[i]) begin
						box_min_q[i] <= pos_q[i];
					end
					if (pos_q[i] > box_max_q[i]) begin
						box_max_q[i] <= pos_q[i];
					end
				end
				scale_ok_q <= 1'b0;
			end
			if (cmd.scale_start) begin
				if (status.side_pos) begin
					cnt_q <= pbcn_pkg::CNT_W'(NW);
				end else begin
					scale_ok_q <= 1'b1;
				end
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.div_finish) begin
				scale_ok_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.scale_ok = scale_ok_q;
		status.side_pos = !side_max[DW-1] && (side_max != '0);
		status.div_last = (cnt_q == pbcn_pkg::CNT_W'(1));
		status.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

@@ rtl/core/point_bbox_calibrate_normalize_unit.sv @@
// Top level of the point bounding-box calibration and normalization unit.
//
//  Channel  | Role   | Beat contents
//  ---------+--------+--------------------------------------------------------
//  points   | sink   | calibrating flag, position, invalid mark, color, frame end
//  results  | source | normalized position, color, last-of-frame mark
//  cfg      | sink   | register index and 16-bit write data, always ready
//
// A calibrating point passes three squares on the shared multiplier, a drain
// step and the radius check with box update before the next ready. A normal
// point goes straight to the scaled products while the scale is current; when
// it must first be recomputed, a step finds the largest side, the one-bit-per-
// cycle restoring divider runs and a rounding step follows. When no box side
// is positive the unit scale is set in the largest-side step and the divider
// is skipped.
// The output register holds a result until it is taken; a new point can
// be accepted meanwhile, and the unit stalls only if a second result is ready.
// Reset clears the box to empty, marks the scale stale and restores registers.
module point_bbox_calibrate_normalize_unit (
	input  logic       clk,
	input  logic       arst_n,
	pbcn_in_if.sink    points,
	pbcn_out_if.source results,
	pbcn_cfg_if.sink   cfg
);

	pbcn_pkg::pbcn_cmd_t cmd;
	pbcn_pkg::pbcn_status_t status;

	// Configuration writes are registered and always taken.
	assign cfg.ready = 1'b1;

	// Input is taken only when the controller sits idle between points.
	assign points.ready = cmd.in_ready;

	pbcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_cal   (points.data.calibrating),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath owns the box, scale, configuration and the result register.
	pbcn_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (points.data),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_wdata (cfg.wdata),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.out_item  (results.data)
	);

endmodule

@@ rtl/core/pbcn_checker.sv @@
// Port-level checker of the normalizer and its bind to the top level.
module pbcn_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input pbcn_pkg::pbcn_out_item_t out_data
);

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// The unit works on one point at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("point accepted while previous one still in work");

	// No result can appear right after a point is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after a point beat");

	// A result is produced only while a point is being worked on.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the unit was idle");

endmodule

bind point_bbox_calibrate_normalize_unit pbcn_checker u_pbcn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

@@ dv/point_bbox_calibrate_normalize_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the point bounding-box calibration and normalization unit.
module point_bbox_calibrate_normalize_unit_tb;

	// Field widths taken from the package.
	localparam int FRAC_W = pbcn_pkg::FRAC_W;
	localparam int COORD_W = pbcn_pkg::COORD_W;
	localparam int PROD_W = pbcn_pkg::PROD_W;
	localparam int COL_W = pbcn_pkg::COL_W;
	localparam int CFG_W = pbcn_pkg::CFG_W;
	localparam int CFG_IDX_W = pbcn_pkg::CFG_IDX_W;

	// Run length and pacing. The slowest item is a normal point that must first
	// recompute the scale, so the limit leaves a wide margin.
	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int MAX_SHOWN = 10;
	localparam int NUM_PHASES = 8;
	localparam int PRESSURE_PHASE = 4;
	localparam int SPARE_PHASE = 5;
	localparam int ONE_M = 1 << FRAC_W;

	// Register indexes that decode to nothing; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	logic clk;
	logic arst_n;

	pbcn_in_if points ();
	pbcn_out_if results ();
	pbcn_cfg_if cfg ();

	point_bbox_calibrate_normalize_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.points(points),
		.results(results),
		.cfg(cfg)
	);

	// Register settings and idle profiles of the random phases. The list covers
	// both extremes of the radius, including a zero radius, and extents from 1 to 65535.
	int phase_radius [NUM_PHASES] = '{65535, 1, 400, 65535, 2500, 0, 10000, 1};
	int phase_extent [NUM_PHASES] = '{65535, 1, 256, 1000, 65535, 128, 7, 65535};
	int phase_tx_idle [NUM_PHASES] = '{0, 52, 0, 8, 0, 52, 0, 8};
	int phase_rx_stall [NUM_PHASES] = '{0, 0, 52, 8, 0, 0, 52, 8};

	// Points waiting to be offered, and the normalized results they are owed.
	pbcn_pkg::pbcn_in_item_t pending_points [$];
	pbcn_pkg::pbcn_out_item_t predicted_norms [$];

	// Shadow copy of the registers and of the box and scale state.
	logic [CFG_W-1:0] radius_sq_reg;
	logic [CFG_W-1:0] extent_reg;
	logic signed [COORD_W-1:0] bb_lo_x, bb_lo_y, bb_lo_z;
	logic signed [COORD_W-1:0] bb_hi_x, bb_hi_y, bb_hi_z;
	logic [PROD_W-1:0] gain;
	logic gain_fresh;

	int tx_idle_pct;
	int rx_stall_pct;
	logic hold_request = 1'b0;
	logic rx_holding = 1'b0;

	int cycle_count = 0;
	int points_taken = 0;
	int cal_taken = 0;
	int results_checked = 0;
	int err_count = 0;

	function automatic logic [PROD_W-1:0] coord_mag(input logic signed [PROD_W-1:0] v);
		return (v < 0) ? PROD_W'(-v) : PROD_W'(v);
	endfunction

	// Scale is target_extent over the largest side, with round-half-up and
	// saturation; a box with no positive side gets a unit scale.
	function automatic void refresh_gain();
		logic signed [PROD_W-1:0] lo_w, hi_w, side, cand;
		logic [PROD_W-1:0] num, den, q, r;
		lo_w = bb_lo_x;
		hi_w = bb_hi_x;
		side = hi_w - lo_w;
		lo_w = bb_lo_y;
		hi_w = bb_hi_y;
		cand = hi_w - lo_w;
		if (cand > side) side = cand;
		lo_w = bb_lo_z;
		hi_w = bb_hi_z;
		cand = hi_w - lo_w;
		if (cand > side) side = cand;
		if (side <= 0) begin
			gain = PROD_W'(pbcn_pkg::SCALE_ONE);
		end else begin
			den = side;
			num = PROD_W'(extent_reg) << (2 * FRAC_W);
			q = num / den;
			r = num % den;
			if (r >= den - r) q = q + 1;
			if (q > PROD_W'(pbcn_pkg::COORD_MAX)) q = PROD_W'(pbcn_pkg::COORD_MAX);
			gain = q;
		end
		gain_fresh = 1'b1;
	endfunction

	// (p - lo) * gain, magnitude rounded half away from zero, then saturated.
	function automatic logic signed [COORD_W-1:0] apply_gain(
			input logic signed [COORD_W-1:0] p, input logic signed [COORD_W-1:0] lo);
		logic signed [PROD_W-1:0] pw, lw, diff;
		logic [PROD_W-1:0] mag, lim;
		pw = p;
		lw = lo;
		diff = pw - lw;
		mag = (coord_mag(diff) * gain + pbcn_pkg::ROUND_HALF) >> FRAC_W;
		lim = (diff < 0) ? PROD_W'(pbcn_pkg::COORD_MAX) + 1 : PROD_W'(pbcn_pkg::COORD_MAX);
		if (mag > lim) mag = lim;
		return (diff < 0) ? COORD_W'(-mag) : COORD_W'(mag);
	endfunction

	// Applies one accepted point to the shadow state and records the result
	// that it owes, if any.
	function automatic void predict_point(input pbcn_pkg::pbcn_in_item_t it);
		logic signed [PROD_W-1:0] xw, yw, zw;
		logic [PROD_W-1:0] sq_dist;
		pbcn_pkg::pbcn_out_item_t res;
		xw = $signed(it.pos_x);
		yw = $signed(it.pos_y);
		zw = $signed(it.pos_z);
		if (it.calibrating) begin
			sq_dist = coord_mag(xw) * coord_mag(xw) + coord_mag(yw) * coord_mag(yw)
				+ coord_mag(zw) * coord_mag(zw);
			if (!it.point_invalid
					&& sq_dist <= (PROD_W'(radius_sq_reg) << (2 * FRAC_W))) begin
				if ($signed(it.pos_x) < bb_lo_x) bb_lo_x = it.pos_x;
				if ($signed(it.pos_y) < bb_lo_y) bb_lo_y = it.pos_y;
				if ($signed(it.pos_z) < bb_lo_z) bb_lo_z = it.pos_z;
				if ($signed(it.pos_x) > bb_hi_x) bb_hi_x = it.pos_x;
				if ($signed(it.pos_y) > bb_hi_y) bb_hi_y = it.pos_y;
				if ($signed(it.pos_z) > bb_hi_z) bb_hi_z = it.pos_z;
				// Even a point already inside the box makes the scale stale.
				gain_fresh = 1'b0;
				cal_taken++;
			end
		end else begin
			if (!gain_fresh) refresh_gain();
			res.norm_x = apply_gain($signed(it.pos_x), bb_lo_x);
			res.norm_y = apply_gain($signed(it.pos_y), bb_lo_y);
			res.norm_z = apply_gain($signed(it.pos_z), bb_lo_z);
			res.out_r = it.col_r;
			res.out_g = it.col_g;
			res.out_b = it.col_b;
			res.last_of_frame = it.frame_end;
			predicted_norms.push_back(res);
		end
	endfunction

	// Largest per-axis magnitude that keeps a point inside the radius sphere.
	function automatic int sphere_bound(input int rsq);
		return int'($sqrt(real'(rsq) / 3.0) * 65536.0);
	endfunction

	function automatic pbcn_pkg::pbcn_in_item_t make_point(input logic cal, input int b,
			input logic wild);
		pbcn_pkg::pbcn_in_item_t it;
		it.calibrating = cal;
		it.point_invalid = 1'b0;
		it.col_r = COL_W'($urandom());
		it.col_g = COL_W'($urandom());
		it.col_b = COL_W'($urandom());
		it.frame_end = 1'($urandom_range(1));
		if (wild) begin
			it.pos_x = $urandom();
			it.pos_y = $urandom();
			it.pos_z = $urandom();
		end else begin
			it.pos_x = COORD_W'(int'($urandom_range(2 * b)) - b);
			it.pos_y = COORD_W'(int'($urandom_range(2 * b)) - b);
			it.pos_z = COORD_W'(int'($urandom_range(2 * b)) - b);
		end
		return it;
	endfunction

	task automatic queue_point(input logic cal, input int x, input int y, input int z,
			input logic inv, input logic [COL_W-1:0] col, input logic fe);
		pbcn_pkg::pbcn_in_item_t it;
		it.calibrating = cal;
		it.pos_x = COORD_W'(x);
		it.pos_y = COORD_W'(y);
		it.pos_z = COORD_W'(z);
		it.point_invalid = inv;
		it.col_r = col;
		it.col_g = ~col;
		it.col_b = col;
		it.frame_end = fe;
		pending_points.push_back(it);
	endtask

	// Frames of well-formed traffic: a short burst of calibration points
	// inside the current sphere, then a run of normal points ending a frame.
	// A minority of calibration points are far, invalid or right on the radius.
	task automatic fill_random(input int want);
		int useful, ncal, nemit, b, rad;
		pbcn_pkg::pbcn_in_item_t it;
		useful = 0;
		b = sphere_bound(radius_sq_reg);
		rad = int'($sqrt(real'(radius_sq_reg)) * 65536.0);
		while (useful < want) begin
			ncal = $urandom_range(5);
			for (int k = 0; k < ncal; k++) begin
				case ($urandom_range(9))
					0: begin
						it = make_point(1'b1, b, 1'b1);
					end
					1: begin
						it = make_point(1'b1, b, 1'b0);
						it.point_invalid = 1'b1;
					end
					2: begin
						it = make_point(1'b1, b, 1'b0);
						it.pos_x = COORD_W'(rad + int'($urandom_range(2)) - 1);
						if ($urandom_range(1)) it.pos_x = -it.pos_x;
						it.pos_y = '0;
						it.pos_z = '0;
						useful++;
					end
					default: begin
						it = make_point(1'b1, b, 1'b0);
						useful++;
					end
				endcase
				pending_points.push_back(it);
			end
			nemit = $urandom_range(12, 1);
			for (int k = 0; k < nemit; k++) begin
				it = make_point(1'b0, 2 * b + ONE_M, $urandom_range(7) == 0);
				// The invalid mark has no effect on a normal point.
				it.point_invalid = 1'($urandom_range(1));
				it.frame_end = (k == nemit - 1) || ($urandom_range(15) == 0);
				pending_points.push_back(it);
				useful++;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			pbcn_pkg::REG_REJECT_RADIUS_SQ: radius_sq_reg = val;
			pbcn_pkg::REG_TARGET_EXTENT: begin
				extent_reg = val;
				gain_fresh = 1'b0;
			end
			default: ;
		endcase
	endtask

	// The idle test runs at the falling edge, where all edge activity has
	// settled. Calibration points leave no result behind, so a tail of cycles
	// lets the last one finish before any register is touched.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_points.size() != 0 || points.valid || predicted_norms.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle budget; reaching it means the unit has hung or lost results.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("point_bbox_calibrate_normalize_unit_tb: done, errors");
			$finish;
		end
	end

	// Point driver. A beat that is offered stays put until it is taken; a new
	// one is offered only after the previous beat moved or while idle, and the
	// sender skips the offer at the rate of the current idle profile.
	always @(posedge clk) begin
		if (!arst_n) begin
			points.valid <= 1'b0;
		end else begin
			if (points.valid && points.ready) begin
				predict_point(points.data);
				points_taken++;
			end
			if (!points.valid || points.ready) begin
				if (pending_points.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					points.valid <= 1'b1;
					points.data <= pending_points.pop_front();
				end else begin
					points.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off. While it lasts the sender keeps offering points,
	// so the output register fills and the unit must stall its input.
	always begin
		wait (hold_request);
		@(posedge clk);
		rx_holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_holding <= 1'b0;
		hold_request = 1'b0;
	end

	// Result monitor. Every result beat is matched against the oldest
	// prediction, field by field; ready is then redrawn for the next cycle.
	always @(posedge clk) begin
		pbcn_pkg::pbcn_out_item_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				results_checked++;
				if (predicted_norms.size() == 0) begin
					err_count++;
					if (err_count <= MAX_SHOWN)
						$display("ERROR: result beat with nothing predicted, cycle %0d",
							cycle_count);
				end else begin
					want = predicted_norms.pop_front();
					if (results.data.norm_x !== want.norm_x
							|| results.data.norm_y !== want.norm_y
							|| results.data.norm_z !== want.norm_z
							|| results.data.out_r !== want.out_r
							|| results.data.out_g !== want.out_g
							|| results.data.out_b !== want.out_b
							|| results.data.last_of_frame !== want.last_of_frame) begin
						err_count++;
						if (err_count <= MAX_SHOWN) begin
							$display("ERROR: result %0d, cycle %0d", results_checked,
								cycle_count);
							$display("  expected xyz %0d %0d %0d rgb %h %h %h last %b",
								$signed(want.norm_x), $signed(want.norm_y),
								$signed(want.norm_z), want.out_r, want.out_g,
								want.out_b, want.last_of_frame);
							$display("  actual   xyz %0d %0d %0d rgb %h %h %h last %b",
								$signed(results.data.norm_x),
								$signed(results.data.norm_y),
								$signed(results.data.norm_z), results.data.out_r,
								results.data.out_g, results.data.out_b,
								results.data.last_of_frame);
						end
					end
				end
			end
			results.ready <= !rx_holding && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		// Every input is known from time zero, and the shadow state starts
		// from the reset values: empty box, stale scale, default registers.
		points.valid = 1'b0;
		points.data = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.wdata = '0;
		radius_sq_reg = pbcn_pkg::RESET_REJECT_RADIUS_SQ;
		extent_reg = pbcn_pkg::RESET_TARGET_EXTENT;
		bb_lo_x = pbcn_pkg::COORD_MAX;
		bb_lo_y = pbcn_pkg::COORD_MAX;
		bb_lo_z = pbcn_pkg::COORD_MAX;
		bb_hi_x = pbcn_pkg::COORD_MIN;
		bb_hi_y = pbcn_pkg::COORD_MIN;
		bb_hi_z = pbcn_pkg::COORD_MIN;
		gain = '0;
		gain_fresh = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset registers. With the box still empty the scale is one
		// and offsets from the most positive value saturate. Then an invalid
		// and an out-of-radius calibration point are dropped, a single point
		// gives a box with zero sides, and a second one a tiny box.
		@(negedge clk);
		queue_point(1'b0, 0, 0, 0, 1'b0, 16'hFFFF, 1'b1);
		queue_point(1'b0, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX,
			1'b0, 16'h0000, 1'b0);
		queue_point(1'b0, pbcn_pkg::COORD_MIN, pbcn_pkg::COORD_MIN, pbcn_pkg::COORD_MIN,
			1'b1, 16'hA5A5, 1'b1);
		queue_point(1'b1, 0, 0, 0, 1'b1, 16'h0000, 1'b0);
		queue_point(1'b1, 11 * ONE_M, 0, 0, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b1, ONE_M * 3 / 2, -(ONE_M * 9 / 4), 3 * ONE_M, 1'b0, 16'h1234, 1'b0);
		queue_point(1'b0, ONE_M * 3 / 2, -(ONE_M * 9 / 4), 3 * ONE_M, 1'b0, 16'h5A5A, 1'b0);
		queue_point(1'b1, ONE_M * 7 / 4, -(ONE_M * 9 / 4), 3 * ONE_M, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b0, ONE_M * 7 / 4, -2 * ONE_M, ONE_M * 13 / 4, 1'b0, 16'h8001, 1'b1);
		wait_idle();

		// Largest target over a quarter-metre box: the scale saturates. A zero
		// radius then admits only the origin.
		write_reg(pbcn_pkg::REG_REJECT_RADIUS_SQ, CFG_W'(0));
		write_reg(pbcn_pkg::REG_TARGET_EXTENT, CFG_W'(65535));
		@(negedge clk);
		queue_point(1'b0, ONE_M * 7 / 4, -(ONE_M * 9 / 4), 3 * ONE_M, 1'b0, 16'h7FFF, 1'b0);
		queue_point(1'b0, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX,
			1'b0, 16'hFFFF, 1'b0);
		queue_point(1'b0, pbcn_pkg::COORD_MIN, pbcn_pkg::COORD_MIN, pbcn_pkg::COORD_MIN,
			1'b0, 16'h0001, 1'b1);
		queue_point(1'b1, ONE_M / 2, 0, 0, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b1, 0, 0, 0, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b0, ONE_M, -ONE_M, 0, 1'b0, 16'h00FF, 1'b1);
		wait_idle();

		// Points exactly on the radius are kept. A point inside the box and an
		// invalid far point follow, then emits that hit zero and both rails.
		write_reg(pbcn_pkg::REG_REJECT_RADIUS_SQ, CFG_W'(100));
		write_reg(pbcn_pkg::REG_TARGET_EXTENT, CFG_W'(1));
		@(negedge clk);
		queue_point(1'b1, 10 * ONE_M, 0, 0, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b1, 0, -10 * ONE_M, 0, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b1, 0, 0, -6 * ONE_M, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b1, 0, 0, 0, 1'b0, 16'h0000, 1'b0);
		queue_point(1'b1, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX,
			1'b1, 16'h0000, 1'b0);
		queue_point(1'b0, -10 * ONE_M, -10 * ONE_M, -6 * ONE_M, 1'b0, 16'hC3C3, 1'b0);
		queue_point(1'b0, 10 * ONE_M, 0, 3 * ONE_M, 1'b0, 16'h3C3C, 1'b0);
		queue_point(1'b0, pbcn_pkg::COORD_MIN, pbcn_pkg::COORD_MIN, pbcn_pkg::COORD_MIN,
			1'b0, 16'hFFFE, 1'b0);
		queue_point(1'b0, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX, pbcn_pkg::COORD_MAX,
			1'b0, 16'h0002, 1'b1);

		// Random phases, each with its own register setting and idle profile.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_reg(pbcn_pkg::REG_REJECT_RADIUS_SQ, CFG_W'(phase_radius[p]));
			write_reg(pbcn_pkg::REG_TARGET_EXTENT, CFG_W'(phase_extent[p]));
			if (p == SPARE_PHASE) begin
				write_reg(REG_SPARE_2, '1);
				write_reg(REG_SPARE_3, CFG_W'(1));
			end
			@(negedge clk);
			tx_idle_pct = phase_tx_idle[p];
			rx_stall_pct = phase_rx_stall[p];
			fill_random(ITEMS_PER_PHASE);
			if (p == PRESSURE_PHASE) hold_request = 1'b1;
		end
		wait_idle();

		$display("Covered %0d point beats (%0d calibration points kept) and %0d results,",
			points_taken, cal_taken, results_checked);
		$display("over %0d register settings, with and without idling and back-pressure.",
			NUM_PHASES + 3);
		if (err_count == 0 && predicted_norms.size() == 0) begin
			$display("point_bbox_calibrate_normalize_unit_tb: done, clean");
		end else begin
			$display("point_bbox_calibrate_normalize_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
